// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is held.
`define HCBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also holds across the reset.
`define HCBD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hcbd_pkg.sv =====
// Types and constants of the chunked HTTP body decoder.
`default_nettype none

package hcbd_pkg;

    localparam int unsigned LEN_W = 17;
    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [1:0] SKIP_BYTES = 2'd2;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       data_out;
        logic             body_done;
        logic [LEN_W-1:0] decoded_length;
    } t_out;

endpackage

`default_nettype wire

// ===== hdl/hcbd_core.sv =====
// Decoder state and the per-byte next-state and result logic.
`default_nettype none

module hcbd_core #(
    parameter int unsigned MAX_BODY_BYTES = 65536
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire hcbd_pkg::t_in i_item,
    output logic               o_res_valid,
    output hcbd_pkg::t_out     o_res
);

    localparam int unsigned CW = $clog2(MAX_BODY_BYTES + 2);
    localparam int unsigned EXT_W = (CW > hcbd_pkg::LEN_W) ? CW : hcbd_pkg::LEN_W;
    localparam logic [CW-1:0] MAX_V = CW'(MAX_BODY_BYTES);
    localparam logic [CW-1:0] MAX_P1 = CW'(MAX_BODY_BYTES + 1);

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_SKIP,
        PH_STOP
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_hex_open, n_hex_open;
    logic            r_cr_seen, n_cr_seen;
    logic [CW-1:0]   r_chunk_size, n_chunk_size;
    logic [CW-1:0]   r_bytes_left, n_bytes_left;
    logic [1:0]      r_skip_left, n_skip_left;
    logic [CW-1:0]   r_committed, n_committed;

    logic [4:0]      w_hex;
    logic [CW+3:0]   w_acc;
    logic [CW:0]     w_sum;
    logic [CW-1:0]   w_left_dec;
    logic [1:0]      w_skip_dec;
    logic            w_emit;
    logic [EXT_W-1:0] w_len_ext;

    function automatic logic [4:0] f_hex(logic [7:0] b);
        logic [4:0] f;
        case (b) inside
            [8'h30:8'h39]: f = {1'b1, b[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: f = {1'b1, 4'(b[3:0] + 4'd9)};
            default:       f = 5'd0;
        endcase
        return f;
    endfunction

    always_comb begin
        w_hex      = f_hex(i_item.body_byte);
        w_acc      = {r_chunk_size, w_hex[3:0]};
        w_sum      = {1'b0, r_committed} + {1'b0, r_chunk_size};
        w_left_dec = r_bytes_left - CW'(1);
        w_skip_dec = r_skip_left - 2'd1;
        w_emit     = 1'b0;

        n_phase      = r_phase;
        n_hex_open   = r_hex_open;
        n_cr_seen    = r_cr_seen;
        n_chunk_size = r_chunk_size;
        n_bytes_left = r_bytes_left;
        n_skip_left  = r_skip_left;
        n_committed  = r_committed;

        case (r_phase)
            PH_SIZE: begin
                if (r_cr_seen && i_item.body_byte == hcbd_pkg::ASCII_LF) begin
                    if (r_chunk_size == '0 || r_chunk_size > MAX_V) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_bytes_left = r_chunk_size;
                        n_phase      = PH_DATA;
                    end
                end else begin
                    if (r_hex_open) begin
                        if (!w_hex[4]) begin
                            n_hex_open = 1'b0;
                        end else if (w_acc > (CW+4)'(MAX_BODY_BYTES)) begin
                            n_chunk_size = MAX_P1;
                        end else begin
                            n_chunk_size = w_acc[CW-1:0];
                        end
                    end
                    n_cr_seen = (i_item.body_byte == hcbd_pkg::ASCII_CR);
                end
            end
            PH_DATA: begin
                w_emit = 1'b1;
                if (r_bytes_left != '0) begin
                    n_bytes_left = w_left_dec;
                end
                if (r_bytes_left == '0 || w_left_dec == '0) begin
                    n_committed = (w_sum > (CW+1)'(MAX_BODY_BYTES)) ? MAX_V : w_sum[CW-1:0];
                    n_skip_left = hcbd_pkg::SKIP_BYTES;
                    n_phase     = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (r_skip_left != 2'd0) begin
                    n_skip_left = w_skip_dec;
                end
                if (r_skip_left == 2'd0 || w_skip_dec == 2'd0) begin
                    n_phase      = PH_SIZE;
                    n_hex_open   = 1'b1;
                    n_cr_seen    = 1'b0;
                    n_chunk_size = '0;
                end
            end
            default: begin
            end
        endcase

        w_len_ext = EXT_W'(n_committed);

        o_res_valid          = w_emit || i_item.final_byte;
        o_res.byte_valid     = w_emit;
        o_res.data_out       = w_emit ? i_item.body_byte : 8'd0;
        o_res.body_done      = i_item.final_byte;
        o_res.decoded_length = i_item.final_byte ? w_len_ext[hcbd_pkg::LEN_W-1:0]
                                                 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.final_byte)) begin
            r_phase      <= PH_SIZE;
            r_hex_open   <= 1'b1;
            r_cr_seen    <= 1'b0;
            r_chunk_size <= '0;
            r_bytes_left <= '0;
            r_skip_left  <= 2'd0;
            r_committed  <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_hex_open   <= n_hex_open;
            r_cr_seen    <= n_cr_seen;
            r_chunk_size <= n_chunk_size;
            r_bytes_left <= n_bytes_left;
            r_skip_left  <= n_skip_left;
            r_committed  <= n_committed;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hcbd_out_buf.sv =====
// Result register with a skid entry behind it.
`default_nettype none

module hcbd_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hcbd_pkg::t_out i_data,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hcbd_pkg::t_out      o_data
);

    logic           r_head_valid, n_head_valid;
    logic           r_skid_valid, n_skid_valid;
    hcbd_pkg::t_out r_head, n_head;
    hcbd_pkg::t_out r_skid, n_skid;
    logic           w_pop;

    always_comb begin
        w_pop        = r_head_valid && i_ready;
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_skid       = i_data;
                n_skid_valid = i_push;
            end else begin
                n_head       = i_data;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end else begin
                n_head       = i_data;
                n_head_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

endmodule

`default_nettype wire

// ===== hdl/http_chunked_body_decoder.sv =====
// Top level of the chunked HTTP body decoder.
// The input channel takes one raw body byte per transaction, with final_byte
// set on the last byte of a body. The output channel carries one transaction
// for every decoded payload byte and one for the final byte, which reports in
// decoded_length the number of bytes in complete chunks; other bytes give no
// output transaction.
// A byte is decoded in the cycle it is accepted and its result is registered in
// the result buffer, behind any results still waiting there. One byte is accepted
// every cycle; the only limit is the two-entry result buffer.
// When the receiver stalls, the result register holds and one more result
// goes to the skid entry; input ready falls only while that entry is full.
// After the final byte the decoder is back in its reset state.
// The synchronous reset clears the decoder state and empties the result
// buffer; input ready is not held low by it, and a byte taken then is dropped.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int unsigned MAX_BODY_BYTES = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire hcbd_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output hcbd_pkg::t_out      o_out_data
);

    logic           w_fire;
    logic           w_full;
    logic           w_res_valid;
    hcbd_pkg::t_out w_res;

    assign o_in_ready = !w_full;
    assign w_fire     = i_in_valid && !w_full;

    hcbd_core #(
        .MAX_BODY_BYTES(MAX_BODY_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (i_in_data),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    hcbd_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fire && w_res_valid),
        .i_data (w_res),
        .o_full (w_full),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_data (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/hcbd_checker.sv =====
// Port-level checker for the chunked HTTP body decoder and its bind.
`default_nettype none

`include "assert_macros.svh"

module hcbd_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire hcbd_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire hcbd_pkg::t_out o_out_data
);

    `HCBD_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `HCBD_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready |-> o_out_valid, "input stalled with no result pending")
    `HCBD_ASSERT(a_result_not_empty, i_clk, i_rst_n, o_out_valid |-> (o_out_data.byte_valid || o_out_data.body_done), "output transaction carries neither a byte nor a body end")
    `HCBD_ASSERT(a_idle_fields_zero, i_clk, i_rst_n, o_out_valid |-> ((o_out_data.byte_valid || o_out_data.data_out == 8'd0) && (o_out_data.body_done || o_out_data.decoded_length == '0)), "unused result field not zero")
    `HCBD_ASSERT(a_stall_holds, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "stalled output transaction changed")

endmodule

bind http_chunked_body_decoder hcbd_checker u_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for the chunked HTTP body decoder, checked against a scoreboard that decodes each byte.
`timescale 1ns / 100ps

class decoder_scoreboard;
    typedef enum logic [1:0] {SIZE_LINE, PAYLOAD, TRAILER, HALTED} t_phase;

    int unsigned max_bytes;
    t_phase phase;
    bit hex_open;
    bit cr_seen;
    bit [16:0] chunk_size;
    bit [16:0] bytes_left;
    bit [1:0] skip_left;
    bit [16:0] committed;
    hcbd_pkg::t_out decoded_q[$];
    int unsigned errors;

    function new(int unsigned body_limit);
        max_bytes = body_limit;
        errors = 0;
        clear_body();
    endfunction

    function void open_line();
        phase = SIZE_LINE;
        hex_open = 1'b1;
        cr_seen = 1'b0;
        chunk_size = '0;
    endfunction

    function void clear_body();
        open_line();
        bytes_left = '0;
        skip_left = '0;
        committed = '0;
    endfunction

    function int hex_value(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        return -1;
    endfunction

    function void take_byte(hcbd_pkg::t_in item);
        int digit;
        int unsigned acc;
        bit emit;
        hcbd_pkg::t_out res;
        emit = 1'b0;
        case (phase)
            SIZE_LINE: begin
                digit = hex_value(item.body_byte);
                if (cr_seen && item.body_byte == hcbd_pkg::ASCII_LF) begin
                    if (chunk_size == 0 || chunk_size > max_bytes) begin
                        phase = HALTED;
                    end else begin
                        bytes_left = chunk_size;
                        phase = PAYLOAD;
                    end
                end else begin
                    if (hex_open) begin
                        if (digit < 0) begin
                            hex_open = 1'b0;
                        end else begin
                            acc = 32'(chunk_size) * 32'd16 + 32'(digit);
                            if (acc > max_bytes) acc = max_bytes + 1;
                            chunk_size = acc[16:0];
                        end
                    end
                    cr_seen = (item.body_byte == hcbd_pkg::ASCII_CR);
                end
            end
            PAYLOAD: begin
                emit = 1'b1;
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0) begin
                    acc = 32'(committed) + 32'(chunk_size);
                    if (acc > max_bytes) acc = max_bytes;
                    committed = acc[16:0];
                    skip_left = hcbd_pkg::SKIP_BYTES;
                    phase = TRAILER;
                end
            end
            TRAILER: begin
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) open_line();
            end
            default: begin
            end
        endcase
        if (emit || item.final_byte) begin
            res.byte_valid = emit;
            res.data_out = emit ? item.body_byte : 8'h00;
            res.body_done = item.final_byte;
            res.decoded_length = item.final_byte ? committed : '0;
            decoded_q.push_back(res);
            if (item.final_byte) clear_body();
        end
    endfunction

    function void field_check(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endfunction

    function void check_output(hcbd_pkg::t_out got);
        hcbd_pkg::t_out want;
        if (decoded_q.size() == 0) begin
            errors++;
            $display("%0t: output transaction with none expected, expected nothing, actual 0x%h",
                     $time, got);
            return;
        end
        want = decoded_q.pop_front();
        field_check("byte_valid", want.byte_valid, got.byte_valid);
        field_check("data_out", want.data_out, got.data_out);
        field_check("body_done", want.body_done, got.body_done);
        field_check("decoded_length", want.decoded_length, got.decoded_length);
    endfunction
endclass

module testbench;

    localparam int unsigned MAX_BODY_BYTES = 65536;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 500;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    hcbd_pkg::t_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    hcbd_pkg::t_out out_data;

    decoder_scoreboard chunk_sb;
    logic [7:0] body_q[$];
    int unsigned chunk_ends[$];
    string hex_chars = "0123456789abcdefABCDEF";
    bit steady = 1'b0;
    int stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;

    http_chunked_body_decoder #(.MAX_BODY_BYTES(MAX_BODY_BYTES)) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) chunk_sb.check_output(out_data);
    end

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(negedge clk) begin
        if (steady) stall_left = 0;
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_length();
        end
    end

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endfunction

    function automatic void append_crlf();
        body_q.push_back(hcbd_pkg::ASCII_CR);
        body_q.push_back(hcbd_pkg::ASCII_LF);
    endfunction

    function automatic void append_chunk(int unsigned size);
        string digits;
        logic [7:0] ch;
        digits = $sformatf("%0h", size);
        if ($urandom_range(0, 3) == 0) body_q.push_back(8'h30);
        for (int i = 0; i < digits.len(); i++) begin
            ch = digits[i];
            if (ch >= 8'h61 && $urandom_range(0, 1) == 1) ch = ch - 8'h20;
            body_q.push_back(ch);
        end
        if ($urandom_range(0, 4) == 0) begin
            body_q.push_back(8'h3B);
            repeat ($urandom_range(1, 6)) begin
                do ch = 8'($urandom_range(0, 255)); while (ch == hcbd_pkg::ASCII_CR);
                body_q.push_back(ch);
            end
        end
        append_crlf();
        repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
        chunk_ends.push_back(body_q.size());
        if ($urandom_range(0, 4) == 0) begin
            repeat (2) body_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            append_crlf();
        end
    endfunction

    function automatic void build_random_body();
        int unsigned cut;
        logic [7:0] ch;
        body_q.delete();
        chunk_ends.delete();
        if ($urandom_range(0, 99) < 75) begin
            repeat ($urandom_range(0, 4)) begin
                append_chunk(($urandom_range(0, 4) == 0) ? $urandom_range(13, 64)
                                                         : $urandom_range(1, 12));
            end
            if ($urandom_range(0, 9) == 0) begin
                body_q.push_back(8'h32 + 8'($urandom_range(0, 7)));
                repeat ($urandom_range(4, 7)) begin
                    body_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
                end
                append_crlf();
            end
            append_text("0");
            append_crlf();
            append_crlf();
            cut = $urandom_range(0, 9);
            if (cut >= 8 || (cut >= 6 && chunk_ends.size() != 0)) begin
                if (cut >= 8) begin
                    cut = $urandom_range(1, body_q.size());
                end else begin
                    cut = chunk_ends[$urandom_range(0, chunk_ends.size() - 1)];
                end
                while (body_q.size() > cut) void'(body_q.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 16)) begin
                case ($urandom_range(0, 3))
                    0: ch = hex_chars[$urandom_range(0, hex_chars.len() - 1)];
                    1: ch = hcbd_pkg::ASCII_CR;
                    2: ch = hcbd_pkg::ASCII_LF;
                    default: ch = 8'($urandom_range(0, 255));
                endcase
                body_q.push_back(ch);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = steady ? 0 : idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{body_byte: b, final_byte: fin};
        do @(posedge clk); while (!in_ready);
        chunk_sb.take_byte(in_data);
        @(negedge clk);
    endtask

    task automatic send_body();
        foreach (body_q[i]) send_byte(body_q[i], i == body_q.size() - 1);
        body_q.delete();
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (chunk_sb.decoded_q.size() != 0);
    endtask

    task automatic send_largest_body();
        steady = 1'b1;
        body_q.delete();
        chunk_ends.delete();
        append_text("10000");
        append_crlf();
        repeat (8) body_q.push_back(8'($urandom_range(0, 255)));
        send_body();
        append_text("10001");
        append_crlf();
        append_chunk(3);
        append_text("0");
        append_crlf();
        append_crlf();
        send_body();
        steady = 1'b0;
    endtask

    initial begin
        int body_count;
        chunk_sb = new(MAX_BODY_BYTES);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        append_text("2;e");
        append_crlf();
        body_q.push_back(8'h00);
        body_q.push_back(8'hFF);
        append_text("x");
        append_crlf();
        append_text("5");
        append_crlf();
        append_text("Z");
        send_body();
        append_text("fFfFf");
        append_crlf();
        append_text("Q");
        send_body();
        append_text("3");
        body_q.push_back(hcbd_pkg::ASCII_CR);
        append_text("A");
        send_body();

        body_count = 0;
        while (items_sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            build_random_body();
            items_sent += body_q.size();
            send_body();
            body_count++;
            if (body_count % 8 == 0) wait_for_results();
            if (body_count == 5) send_largest_body();
        end
        steady = 1'b0;
        wait_for_results();
        repeat (4) @(negedge clk);
        if (chunk_sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
